// ----- hw/rtl/bol_pkg.sv -----
package bol_pkg;

  localparam int CAPACITY   = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int POS_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Operation codes carried in the input tuser.
  localparam logic [2:0] FN_CLEAR  = 3'd0;
  localparam logic [2:0] FN_INSERT = 3'd1;
  localparam logic [2:0] FN_DELETE = 3'd2;
  localparam logic [2:0] FN_FIND   = 3'd3;
  localparam logic [2:0] FN_READ   = 3'd4;
  localparam logic [2:0] FN_WRITE  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  typedef logic [ITEM_WIDTH-1:0] item_t;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    item_t    load_data;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/bounded_ordered_list_core.sv -----
// The result word on out_tdata is registered: it appears in the cycle after its input word is accepted.
// Throughput: one operation per cycle; every cell of the entry chain shifts, loads
// or compares in the same cycle. A result word held by a stalled sink holds off
// the input until it is taken.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// entry storage is not cleared and is only read below the current length.
module bounded_ordered_list_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[3:0], at_end[4], value_in[36:5], zero pad
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], found_position[5:2],
                                  // value_out[37:6], length[42:38], zero pad
);

  localparam int CAP = bol_pkg::CAPACITY;
  localparam int CW  = bol_pkg::CNT_W;
  localparam int PW  = bol_pkg::POS_W;

  logic [2:0]     in_func;
  logic [3:0]     in_position;
  logic           in_at_end;
  logic [31:0]    in_value;
  logic           in_fire;

  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           out_valid_r;
  logic [1:0]     status_r;
  logic [1:0]     status_nxt;
  logic [3:0]     found_r;
  logic [3:0]     found_nxt;
  logic [31:0]    rd_r;
  logic [31:0]    rd_nxt;

  logic [CW-1:0]  pos_ext;
  logic [CW-1:0]  where;
  logic           not_full;
  logic           pos_ok;
  logic           ins_go;
  logic           del_go;
  logic           wr_go;
  logic           any_match;
  logic [3:0]     match_pos;
  bol_pkg::item_t key;

  bol_pkg::item_t     cell_data [CAP];
  logic [CAP-1:0]     cell_match;
  bol_pkg::cell_ctl_t cell_ctl  [CAP];

  assign in_position = in_tdata[3:0];
  assign in_at_end   = in_tdata[4];
  assign in_value    = in_tdata[36:5];
  assign in_func     = in_tuser;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign key      = bol_pkg::ITEM_WIDTH'(in_value);
  assign pos_ext  = CW'(in_position);
  assign where    = in_at_end ? count_r : pos_ext;
  assign not_full = (count_r < CW'(CAP));
  assign pos_ok   = (pos_ext < count_r);

  assign ins_go = in_fire && (in_func == bol_pkg::FN_INSERT) && not_full && (where <= count_r);
  assign del_go = in_fire && (in_func == bol_pkg::FN_DELETE) && pos_ok;
  assign wr_go  = in_fire && (in_func == bol_pkg::FN_WRITE) && pos_ok;

  // Per-cell commands: insert opens a gap at 'where' by moving higher cells up one
  // place; delete closes the gap at the position by pulling higher cells down.
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      cell_ctl[i].load_data = key;
      cell_ctl[i].op        = bol_pkg::CELL_HOLD;
      if (ins_go) begin
        if (CW'(i) == where) begin
          cell_ctl[i].op = bol_pkg::CELL_LOAD;
        end else if ((CW'(i) > where) && (CW'(i) <= count_r)) begin
          cell_ctl[i].op = bol_pkg::CELL_FROM_LOWER;
        end
      end else if (del_go) begin
        if ((CW'(i) >= pos_ext) && ((CW'(i) + CW'(1)) < count_r)) begin
          cell_ctl[i].op = bol_pkg::CELL_FROM_UPPER;
        end
      end else if (wr_go) begin
        if (CW'(i) == pos_ext) begin
          cell_ctl[i].op = bol_pkg::CELL_LOAD;
        end
      end
    end
  end

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    bol_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .lower_data ((g == 0) ? bol_pkg::item_t'('0) : cell_data[(g == 0) ? 0 : g - 1]),
      .upper_data ((g == CAP - 1) ? bol_pkg::item_t'('0)
                                  : cell_data[(g == CAP - 1) ? g : g + 1]),
      .key        (key),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

  // First live cell that matches the key; scanned from the top so the lowest wins.
  always_comb begin
    any_match = 1'b0;
    match_pos = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (cell_match[i] && (CW'(i) < count_r)) begin
        any_match = 1'b1;
        match_pos = 4'(i);
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = bol_pkg::ST_OK;
    found_nxt  = '0;
    rd_nxt     = '0;
    unique case (in_func)
      bol_pkg::FN_CLEAR: begin
        count_nxt = '0;
      end
      bol_pkg::FN_INSERT: begin
        if (!not_full) begin
          status_nxt = bol_pkg::ST_FULL;
        end else if (where > count_r) begin
          status_nxt = bol_pkg::ST_RANGE;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      bol_pkg::FN_DELETE: begin
        if (!pos_ok) begin
          status_nxt = bol_pkg::ST_RANGE;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      bol_pkg::FN_FIND: begin
        if (any_match) begin
          found_nxt = match_pos;
        end else begin
          status_nxt = bol_pkg::ST_NOT_FOUND;
        end
      end
      bol_pkg::FN_READ: begin
        if (!pos_ok) begin
          status_nxt = bol_pkg::ST_RANGE;
        end else begin
          rd_nxt = 32'(cell_data[pos_ext[PW-1:0]]);
        end
      end
      bol_pkg::FN_WRITE: begin
        if (!pos_ok) begin
          status_nxt = bol_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      rd_r     <= rd_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, 5'(count_r), rd_r, found_r, status_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("list length exceeds capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_func == bol_pkg::FN_CLEAR) |=> (count_r == '0) && out_tvalid)
    else $error("clear did not empty the list");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_func == bol_pkg::FN_INSERT) && (count_r == CW'(CAP))
    |=> (status_r == bol_pkg::ST_FULL) && $stable(count_r))
    else $error("insert into a full list was not rejected");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_go |=> (count_r == $past(count_r) + CW'(1)) && (status_r == bol_pkg::ST_OK))
    else $error("insert did not grow the list by one");

endmodule

// ----- hw/rtl/bol_cell.sv -----
module bol_cell (
  input  logic               clk,
  input  bol_pkg::cell_ctl_t ctl,
  input  bol_pkg::item_t     lower_data,
  input  bol_pkg::item_t     upper_data,
  input  bol_pkg::item_t     key,
  output bol_pkg::item_t     data,
  output logic               match
);

  bol_pkg::item_t data_r;
  bol_pkg::item_t data_nxt;

  always_comb begin
    unique case (ctl.op)
      bol_pkg::CELL_HOLD:       data_nxt = data_r;
      bol_pkg::CELL_LOAD:       data_nxt = ctl.load_data;
      bol_pkg::CELL_FROM_LOWER: data_nxt = lower_data;
      bol_pkg::CELL_FROM_UPPER: data_nxt = upper_data;
      default:                  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == key);

endmodule

// ----- verif/bounded_ordered_list_core_tb.sv -----
module bounded_ordered_list_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = bol_pkg::CAPACITY;
  localparam int POS_W    = bol_pkg::POS_W;
  localparam int CNT_W    = bol_pkg::CNT_W;

  typedef bol_pkg::item_t item_t;

  // Codes six and seven select no operation.
  localparam logic [2:0] FN_SPARE_6 = 3'd6;
  localparam logic [2:0] FN_SPARE_7 = 3'd7;

  localparam int RANDOM_WORDS = 1600;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] found_pos;
    item_t            value;
    logic [CNT_W-1:0] length;
  } list_result_t;

  typedef struct {
    logic [2:0]       func;
    logic [POS_W-1:0] pos;
    logic             at_end;
    item_t            value;
    int               reps;
    bit               typed;
    list_result_t     want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  // Shadow copy of the list, advanced on every accepted input word.
  item_t        shadow_entries [CAPACITY];
  int           shadow_count;
  list_result_t results_due [$];
  int           errors;
  int           calm_left [2];

  // Expectation typed into the directed table for the word on the bus.
  bit           drv_typed;
  list_result_t drv_want;

  bounded_ordered_list_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic list_result_t apply_list_op(logic [2:0] func, logic [POS_W-1:0] pos,
                                                 logic at_end, item_t value);
    list_result_t r;
    int           where;
    int           i;
    r = '0;
    r.status = bol_pkg::ST_OK;
    case (func)
      bol_pkg::FN_CLEAR: begin
        shadow_count = 0;
      end
      bol_pkg::FN_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = bol_pkg::ST_FULL;
        end else begin
          where = at_end ? shadow_count : int'(pos);
          if (where > shadow_count) begin
            r.status = bol_pkg::ST_RANGE;
          end else begin
            for (i = shadow_count; i > where; i--) shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[where] = value;
            shadow_count++;
          end
        end
      end
      bol_pkg::FN_DELETE: begin
        if (int'(pos) >= shadow_count) begin
          r.status = bol_pkg::ST_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      bol_pkg::FN_FIND: begin
        r.status = bol_pkg::ST_NOT_FOUND;
        for (i = 0; i < shadow_count; i++) begin
          if (r.status != bol_pkg::ST_OK && shadow_entries[i] == value) begin
            r.status = bol_pkg::ST_OK;
            r.found_pos = POS_W'(i);
          end
        end
      end
      bol_pkg::FN_READ: begin
        if (int'(pos) >= shadow_count) r.status = bol_pkg::ST_RANGE;
        else r.value = shadow_entries[pos];
      end
      bol_pkg::FN_WRITE: begin
        if (int'(pos) >= shadow_count) r.status = bol_pkg::ST_RANGE;
        else shadow_entries[pos] = value;
      end
      default: begin
      end
    endcase
    r.length = CNT_W'(shadow_count);
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int pick_gap(int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left[side] = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic plan_row_t mk_row(logic [2:0] func, int pos, bit at_end, item_t value,
                                       int reps, bit typed, logic [1:0] status, int found_pos,
                                       item_t value_out, int length);
    plan_row_t row;
    row.func   = func;
    row.pos    = POS_W'(pos);
    row.at_end = at_end;
    row.value  = value;
    row.reps   = reps;
    row.typed  = typed;
    row.want.status    = status;
    row.want.found_pos = POS_W'(found_pos);
    row.want.value     = value_out;
    row.want.length    = CNT_W'(length);
    return row;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic [2:0] func, logic [POS_W-1:0] pos, logic at_end,
                           item_t value, bit typed, list_result_t want);
    int gap;
    gap = pick_gap(0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, value, at_end, pos};
    in_tuser  <= func;
    drv_typed <= typed;
    drv_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : accept_mon
    list_result_t r;
    if (rst_n && in_tvalid && in_tready) begin
      r = apply_list_op(in_tuser, in_tdata[3:0], in_tdata[4], in_tdata[36:5]);
      if (drv_typed) r = drv_want;
      results_due.push_back(r);
    end
  end

  always @(posedge clk) begin : result_mon
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $error("result word with no operation outstanding: %h", out_tdata);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (out_tdata[1:0] != want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[1:0]);
          errors++;
        end
        if (out_tdata[5:2] != want.found_pos) begin
          $error("found_position: expected %0d, got %0d", want.found_pos, out_tdata[5:2]);
          errors++;
        end
        if (out_tdata[37:6] != want.value) begin
          $error("value_out: expected %h, got %h", want.value, out_tdata[37:6]);
          errors++;
        end
        if (out_tdata[42:38] != want.length) begin
          $error("length: expected %0d, got %0d", want.length, out_tdata[42:38]);
          errors++;
        end
      end
    end
  end

  initial begin : sink_ready
    int hold;
    int pause;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    out_tready <= 1'b1;
    forever begin
      hold = $urandom_range(1, 8);
      repeat (hold) @(negedge clk);
      pause = pick_gap(1);
      if (pause > 0) begin
        out_tready <= 1'b0;
        repeat (pause) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("bounded_ordered_list_core test failed");
    $finish;
  end

  initial begin : stimulus
    plan_row_t    plan [$];
    plan_row_t    row;
    list_result_t none;
    logic [2:0]   func;
    logic [POS_W-1:0] pos;
    logic         at_end;
    item_t        value;
    bit           filling;
    int           r;
    int           ins_w;
    int           del_w;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = bol_pkg::FN_CLEAR;
    drv_typed    = 1'b0;
    drv_want     = '0;
    errors       = 0;
    shadow_count = 0;
    calm_left[0] = 0;
    calm_left[1] = 0;
    none         = '0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;

    // Empty list: every position is out of range, find misses.
    plan.push_back(mk_row(bol_pkg::FN_READ, 0, 0, 32'h0, 1, 1,
                          bol_pkg::ST_RANGE, 0, 32'h0, 0));
    plan.push_back(mk_row(bol_pkg::FN_FIND, 0, 0, 32'h0, 1, 1,
                          bol_pkg::ST_NOT_FOUND, 0, 32'h0, 0));
    plan.push_back(mk_row(bol_pkg::FN_DELETE, 15, 0, 32'h0, 1, 1,
                          bol_pkg::ST_RANGE, 0, 32'h0, 0));
    plan.push_back(mk_row(bol_pkg::FN_WRITE, 0, 0, 32'h1, 1, 1,
                          bol_pkg::ST_RANGE, 0, 32'h0, 0));
    plan.push_back(mk_row(bol_pkg::FN_INSERT, 1, 0, 32'h1, 1, 1,
                          bol_pkg::ST_RANGE, 0, 32'h0, 0));
    // Append ignores the position; a position equal to the length appends too.
    plan.push_back(mk_row(bol_pkg::FN_INSERT, 15, 1, 32'hFFFFFFFF, 1, 1,
                          bol_pkg::ST_OK, 0, 32'h0, 1));
    plan.push_back(mk_row(bol_pkg::FN_INSERT, 0, 0, 32'h0, 1, 1,
                          bol_pkg::ST_OK, 0, 32'h0, 2));
    plan.push_back(mk_row(bol_pkg::FN_INSERT, 2, 0, 32'h5A5AA5A5, 1, 1,
                          bol_pkg::ST_OK, 0, 32'h0, 3));
    plan.push_back(mk_row(bol_pkg::FN_READ, 1, 0, 32'h0, 1, 1,
                          bol_pkg::ST_OK, 0, 32'hFFFFFFFF, 3));
    plan.push_back(mk_row(bol_pkg::FN_READ, 3, 0, 32'h0, 1, 1,
                          bol_pkg::ST_RANGE, 0, 32'h0, 3));
    plan.push_back(mk_row(bol_pkg::FN_FIND, 0, 0, 32'hFFFFFFFF, 1, 1,
                          bol_pkg::ST_OK, 1, 32'h0, 3));
    plan.push_back(mk_row(bol_pkg::FN_WRITE, 2, 0, 32'hA5A55A5A, 1, 0,
                          bol_pkg::ST_OK, 0, 32'h0, 0));
    plan.push_back(mk_row(bol_pkg::FN_READ, 2, 0, 32'h0, 1, 0,
                          bol_pkg::ST_OK, 0, 32'h0, 0));
    plan.push_back(mk_row(bol_pkg::FN_DELETE, 0, 0, 32'h0, 1, 1,
                          bol_pkg::ST_OK, 0, 32'h0, 2));
    plan.push_back(mk_row(FN_SPARE_6, 15, 1, 32'hFFFFFFFF, 1, 1,
                          bol_pkg::ST_OK, 0, 32'h0, 2));
    plan.push_back(mk_row(FN_SPARE_7, 0, 0, 32'h0, 1, 1,
                          bol_pkg::ST_OK, 0, 32'h0, 2));
    plan.push_back(mk_row(bol_pkg::FN_CLEAR, 0, 0, 32'h0, 1, 1,
                          bol_pkg::ST_OK, 0, 32'h0, 0));
    // Fill to capacity with distinct values, then push against the full list.
    plan.push_back(mk_row(bol_pkg::FN_INSERT, 0, 1, 32'h80000000, CAPACITY, 0,
                          bol_pkg::ST_OK, 0, 32'h0, 0));
    plan.push_back(mk_row(bol_pkg::FN_INSERT, 3, 0, 32'h1, 1, 1,
                          bol_pkg::ST_FULL, 0, 32'h0, CAPACITY));
    plan.push_back(mk_row(bol_pkg::FN_INSERT, 0, 1, 32'h1, 1, 1,
                          bol_pkg::ST_FULL, 0, 32'h0, CAPACITY));
    plan.push_back(mk_row(bol_pkg::FN_FIND, 0, 0, 32'h8000000F, 1, 0,
                          bol_pkg::ST_OK, 0, 32'h0, 0));
    plan.push_back(mk_row(bol_pkg::FN_READ, 15, 0, 32'h0, 1, 0,
                          bol_pkg::ST_OK, 0, 32'h0, 0));
    plan.push_back(mk_row(bol_pkg::FN_DELETE, 15, 0, 32'h0, 1, 0,
                          bol_pkg::ST_OK, 0, 32'h0, 0));
    plan.push_back(mk_row(bol_pkg::FN_CLEAR, 0, 0, 32'h0, 1, 1,
                          bol_pkg::ST_OK, 0, 32'h0, 0));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[k]) begin
      row = plan[k];
      for (int n = 0; n < row.reps; n++) begin
        send_word(row.func, row.pos, row.at_end, row.value + item_t'(n), row.typed, row.want);
      end
    end

    // Random part: alternate between growing and shrinking the list so that
    // both the empty and the full ends are reached many times.
    filling = 1'b1;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (shadow_count == 0) filling = 1'b1;
      else if (shadow_count == CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if ($urandom_range(0, 49) == 0) filling = !filling;
      ins_w = filling ? 45 : 12;
      del_w = filling ? 10 : 40;

      r = $urandom_range(0, 99);
      if (r < ins_w) func = bol_pkg::FN_INSERT;
      else if (r < ins_w + del_w) func = bol_pkg::FN_DELETE;
      else if (r < 90) begin
        case (r % 3)
          0: func = bol_pkg::FN_FIND;
          1: func = bol_pkg::FN_READ;
          default: func = bol_pkg::FN_WRITE;
        endcase
      end else if (r < 92) func = bol_pkg::FN_CLEAR;
      else if (r < 94) func = r[0] ? FN_SPARE_7 : FN_SPARE_6;
      else func = bol_pkg::FN_FIND;

      if ($urandom_range(0, 99) < 85 && shadow_count > 0) begin
        if (func == bol_pkg::FN_INSERT) pos = POS_W'($urandom_range(0,
                                          (shadow_count < CAPACITY) ? shadow_count
                                                                    : CAPACITY - 1));
        else pos = POS_W'($urandom_range(0, shadow_count - 1));
      end else begin
        pos = POS_W'($urandom_range(0, CAPACITY - 1));
      end
      at_end = ($urandom_range(0, 9) < 3);

      r = $urandom_range(0, 99);
      if (func == bol_pkg::FN_FIND && shadow_count > 0 && r < 60)
        value = shadow_entries[$urandom_range(0, shadow_count - 1)];
      else if (r < 75) value = $urandom();
      else if (r < 92) value = item_t'($urandom_range(0, 3));
      else value = r[0] ? '1 : '0;

      send_word(func, pos, at_end, value, 1'b0, none);
    end
    in_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("bounded_ordered_list_core test passed");
    end else begin
      $display("bounded_ordered_list_core test failed");
    end
    $finish;
  end

endmodule
